// ===== sv/sbet_pkg.sv =====
// ----------------------------------------------------------------------------
// sbet_pkg
// shared constants and types for the swept box entry time block
// ----------------------------------------------------------------------------
package sbet_pkg;

  localparam int COORD_BITS_DEF     = 16;
  localparam int TIME_FRAC_BITS_DEF = 15;
  localparam int ENTRY_BITS         = 16;

  // control flags that ride along the divider chain
  typedef struct packed {
    logic valid;
    logic hit;
  } sbet_ctl_t;

endpackage

// ===== sv/swept_box_entry_time_top.sv =====
// ----------------------------------------------------------------------------
// swept_box_entry_time_top
// swept box entry time: hit flag and rounded entry fraction per box pair
// ----------------------------------------------------------------------------
// path: front stages, then the divider cells, then the output register
// throughput: one transaction per cycle unless out_stall holds a full output
// register, set by the divider cell chain, which produces one quotient bit per cell
// reset: synchronous rst clears all valid flags, no data is cleared
module swept_box_entry_time_top import sbet_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] a_left,
  input  logic signed [COORD_BITS-1:0] a_right,
  input  logic signed [COORD_BITS-1:0] a_top,
  input  logic signed [COORD_BITS-1:0] a_bottom,
  input  logic signed [COORD_BITS-1:0] a_vel_x,
  input  logic signed [COORD_BITS-1:0] a_vel_y,
  input  logic signed [COORD_BITS-1:0] b_left,
  input  logic signed [COORD_BITS-1:0] b_right,
  input  logic signed [COORD_BITS-1:0] b_top,
  input  logic signed [COORD_BITS-1:0] b_bottom,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic [ENTRY_BITS-1:0]        entry_time
);

  // one extra quotient bit for round to nearest, one for the integer bit
  localparam int QB = TIME_FRAC_BITS + 2;
  localparam int NC = QB;

  // whole pipe advances unless the output register is full and stalled
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  sbet_ctl_t              f_ctl;
  logic [COORD_BITS:0]    f_num, f_den;

  sbet_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .en, .in_valid,
    .a_left, .a_right, .a_top, .a_bottom, .a_vel_x, .a_vel_y,
    .b_left, .b_right, .b_top, .b_bottom,
    .ctl(f_ctl), .num(f_num), .den(f_den)
  );

  // divider chain: quotient of num * 2^(QB-1) / den, num <= den here
  sbet_ctl_t             c_ctl [NC+1];
  logic [COORD_BITS+1:0] c_rem [NC+1];
  logic [COORD_BITS:0]   c_den [NC+1];
  logic [QB-1:0]         c_q   [NC+1];

  // first cell compares num itself and yields the integer bit
  assign c_ctl[0] = f_ctl;
  assign c_rem[0] = {1'b0, f_num};
  assign c_den[0] = f_den;
  assign c_q[0]   = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    sbet_div_cell #(.COORD_BITS(COORD_BITS), .QB(QB)) u_cell (
      .clk, .rst, .en,
      .ctl_in(c_ctl[i]), .rem_in(c_rem[i]), .den_in(c_den[i]), .q_in(c_q[i]),
      .ctl_out(c_ctl[i+1]), .rem_out(c_rem[i+1]), .den_out(c_den[i+1]),
      .q_out(c_q[i+1])
    );
  end

  // truncated quotient of num*2^(QB-1)/den, rounding from its lsb; a miss gives 1.0
  logic [QB-1:0] qfix;
  logic [QB:0]   qround;
  logic [QB:0]   qsel;
  always_comb begin
    qfix   = c_q[NC];
    qround = ({1'b0, qfix} + (QB+1)'(1)) >> 1;
    qsel   = c_ctl[NC].hit ? qround : ((QB+1)'(1) << TIME_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_ctl[NC].valid;
    end
    if (en) begin
      hit        <= c_ctl[NC].hit;
      entry_time <= ENTRY_BITS'(qsel);
    end
  end

endmodule

// ===== sv/sbet_front.sv =====
// ----------------------------------------------------------------------------
// sbet_front
// per-axis distances, sweep tests and choice of the later entry
// ----------------------------------------------------------------------------
module sbet_front import sbet_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] a_left,
  input  logic signed [COORD_BITS-1:0] a_right,
  input  logic signed [COORD_BITS-1:0] a_top,
  input  logic signed [COORD_BITS-1:0] a_bottom,
  input  logic signed [COORD_BITS-1:0] a_vel_x,
  input  logic signed [COORD_BITS-1:0] a_vel_y,
  input  logic signed [COORD_BITS-1:0] b_left,
  input  logic signed [COORD_BITS-1:0] b_right,
  input  logic signed [COORD_BITS-1:0] b_top,
  input  logic signed [COORD_BITS-1:0] b_bottom,
  output sbet_ctl_t                    ctl,
  output logic        [COORD_BITS:0]   num,
  output logic        [COORD_BITS:0]   den
);

  localparam int DW = COORD_BITS + 2;   // distance width
  localparam int MW = 2 * DW;           // cross product width

  // stage 1 registers
  logic                 s1_valid;
  logic signed [DW-1:0] xen_n, xex_n, yen_n, yex_n;
  logic signed [DW-1:0] xd, yd;
  logic                 xinf, yinf, above;

  logic signed [DW-1:0] dxen, dxex, dyen, dyex, mvx, mvy;

  always_comb begin
    if (a_vel_x > 0) begin
      dxen = DW'(b_left) - DW'(a_right);
      dxex = DW'(b_right) - DW'(a_left);
    end else begin
      dxen = DW'(b_right) - DW'(a_left);
      dxex = DW'(b_left) - DW'(a_right);
    end
    if (a_vel_y > 0) begin
      dyen = DW'(b_top) - DW'(a_bottom);
      dyex = DW'(b_bottom) - DW'(a_top);
    end else begin
      dyen = DW'(b_bottom) - DW'(a_top);
      dyex = DW'(b_top) - DW'(a_bottom);
    end
    mvx = DW'(a_vel_x);
    mvy = DW'(a_vel_y);
    if (a_vel_x < 0) begin
      dxen = -dxen; dxex = -dxex; mvx = -mvx;
    end
    if (a_vel_y < 0) begin
      dyen = -dyen; dyex = -dyex; mvy = -mvy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      xen_n <= dxen; xex_n <= dxex; yen_n <= dyen; yex_n <= dyex;
      xd    <= mvx;  yd    <= mvy;
      xinf  <= (a_vel_x == '0);
      yinf  <= (a_vel_y == '0);
      above <= (a_bottom <= b_top);
    end
  end

  // stage 2: cross products for the exact compares
  logic signed [MW-1:0] p_xen_yd, p_yex_xd, p_yen_xd, p_xex_yd;
  logic                 s2_valid, s2_xinf, s2_yinf, s2_above;
  logic                 l_xx, l_yy, xneg, yneg, xone, yone;
  logic signed [DW-1:0] s2_xn, s2_yn, s2_xd, s2_yd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      p_xen_yd <= MW'(xen_n) * MW'(yd);
      p_yex_xd <= MW'(yex_n) * MW'(xd);
      p_yen_xd <= MW'(yen_n) * MW'(xd);
      p_xex_yd <= MW'(xex_n) * MW'(yd);
      l_xx     <= !xinf && (xen_n > xex_n);
      l_yy     <= !yinf && (yen_n > yex_n);
      xneg     <= xinf || (xen_n < 0);
      yneg     <= yinf || (yen_n < 0);
      xone     <= !xinf && (xen_n > xd);
      yone     <= !yinf && (yen_n > yd);
      s2_xinf  <= xinf; s2_yinf <= yinf; s2_above <= above;
      s2_xn    <= xen_n; s2_yn <= yen_n; s2_xd <= xd; s2_yd <= yd;
    end
  end

  // stage 3: decision and pick of the later entry
  logic l_xy, l_yx, ok, pick_x;

  always_comb begin
    l_xy   = !s2_xinf && !s2_yinf && (p_xen_yd > p_yex_xd);
    l_yx   = !s2_xinf && !s2_yinf && (p_yen_xd > p_xex_yd);
    ok     = !(l_xx || l_yy || l_xy || l_yx) && !(xneg && yneg) &&
             !(xone || yone) && s2_above;
    pick_x = s2_yinf || (!s2_xinf && (p_xen_yd >= p_yen_xd));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= s2_valid;
    end
    if (en) begin
      ctl.hit <= ok;
      num <= pick_x ? s2_xn[COORD_BITS:0] : s2_yn[COORD_BITS:0];
      den <= pick_x ? s2_xd[COORD_BITS:0] : s2_yd[COORD_BITS:0];
    end
  end

endmodule

// ===== sv/sbet_div_cell.sv =====
// ----------------------------------------------------------------------------
// sbet_div_cell
// one restoring quotient-bit step of the divider chain
// ----------------------------------------------------------------------------
module sbet_div_cell import sbet_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int QB         = TIME_FRAC_BITS_DEF + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  sbet_ctl_t             ctl_in,
  input  logic [COORD_BITS+1:0] rem_in,
  input  logic [COORD_BITS:0]   den_in,
  input  logic [QB-1:0]         q_in,
  output sbet_ctl_t             ctl_out,
  output logic [COORD_BITS+1:0] rem_out,
  output logic [COORD_BITS:0]   den_out,
  output logic [QB-1:0]         q_out
);

  // remainder stays below twice the divisor, so after the subtract it fits
  logic [COORD_BITS+1:0] df, rsel;
  logic                  ge;

  always_comb begin
    ge   = (rem_in >= {1'b0, den_in});
    df   = rem_in - {1'b0, den_in};
    rsel = ge ? df : rem_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.hit <= ctl_in.hit;
      rem_out     <= {rsel[COORD_BITS:0], 1'b0};
      den_out     <= den_in;
      q_out       <= {q_in[QB-2:0], ge};
    end
  end

endmodule
